// ===== design/port_reply_line_parser_assert.svh =====
// assertion macros for the port reply line parser
// each macro expects clk_i and rst_ni in scope
`ifndef PORT_REPLY_LINE_PARSER_ASSERT_SVH
`define PORT_REPLY_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define PRLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/prlp_pkg.sv =====
// ----------------------------------------------------------------------------
// prlp_pkg
// Shared widths, character codes and status codes of the reply line parser.
// ----------------------------------------------------------------------------
package prlp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACC_W  = DATA_W + 4;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned STAT_W = 3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [ACC_W-1:0] MAG_LIM_POS = ACC_W'(64'h7FFF_FFFF);
  localparam logic [ACC_W-1:0] MAG_LIM_NEG = ACC_W'(64'h8000_0000);

  localparam logic [DATA_W-1:0] NEG_ONE = '1;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_COLON  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ORDER = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_PFX   = 3'd3;
  localparam logic [STAT_W-1:0] ST_IDX_RANGE = 3'd4;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ===== design/prlp_num_acc.sv =====
// ----------------------------------------------------------------------------
// prlp_num_acc
// Decimal accumulate step: magnitude times ten plus one digit, with the
// signed 32-bit range check for the current sign.
// ----------------------------------------------------------------------------
module prlp_num_acc
  import prlp_pkg::*;
(
  input  logic [DATA_W-1:0] acc_i,
  input  logic              negative_i,
  input  logic [3:0]        digit_i,
  output logic [DATA_W-1:0] sum_o,
  output logic              ok_o
);

  logic [ACC_W-1:0] acc_x;
  logic [ACC_W-1:0] wide;
  logic [ACC_W-1:0] limit;

  // times ten as two shifts, room for the carry out
  assign acc_x = ACC_W'(acc_i);
  assign wide  = (acc_x << 3) + (acc_x << 1) + ACC_W'(digit_i);
  assign limit = negative_i ? MAG_LIM_NEG : MAG_LIM_POS;
  assign ok_o  = (wide <= limit);
  assign sum_o = wide[DATA_W-1:0];

endmodule

// ===== design/port_reply_line_parser.sv =====
// ----------------------------------------------------------------------------
// port_reply_line_parser
// Parses one controller reply line, a byte per word, into a port number, a
// picked list number and a status code.
// ----------------------------------------------------------------------------
// Input channel: one byte of the line per word (char_code_i), the wanted list
// position (wanted_index_i, taken from the first byte of each line only) and
// line_end_i on the last byte. Output channel: one word per line, sent for
// the byte that carries line_end_i, with port_number_o, picked_number_o and
// parse_status_o (0 ok, 1 no colon, 2 P/C order, 3 bad prefix, 4 index range).
// Throughput: one byte per cycle. Each byte is held in an input register,
// then one pass of logic (a times-ten accumulate for prefix and list each)
// updates the line state and, on line end, loads the result register.
// The last byte of a line passes from the input register into the result
// register, which then holds the reply with out_valid_o high.
// When the receiver stalls, bytes keep flowing until a line end byte finds
// the result register still full; it then waits in the input register and
// in_ready_o drops until the result is taken.
// Reset: all line state is cleared, no result is pending; the state also
// returns to this clean form after every line end.
// ----------------------------------------------------------------------------
module port_reply_line_parser
  import prlp_pkg::*;
#(
  parameter int unsigned MAX_NUMBERS = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               char_code_i,
  input  logic signed [IDX_W-1:0]  wanted_index_i,
  input  logic                     line_end_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] port_number_o,
  output logic signed [DATA_W-1:0] picked_number_o,
  output logic [STAT_W-1:0]        parse_status_o
);

  localparam int unsigned CntW = $clog2(MAX_NUMBERS + 1);
  localparam int unsigned CmpW = (CntW > IDX_W) ? CntW : IDX_W;

  // token parser phases
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  // input register
  logic             in_valid_q;
  logic [7:0]       char_q;
  logic [IDX_W-1:0] idx_in_q;
  logic             end_q;
  logic             s1_fire;

  // line state
  logic              colon_q, colon_d;
  logic              p_seen_q, p_seen_d;
  logic              c_after_q, c_after_d;
  logic              c_before_q, c_before_d;
  logic [1:0]        pfx_phase_q, pfx_phase_d;
  logic              pfx_neg_q, pfx_neg_d;
  logic [DATA_W-1:0] pfx_acc_q, pfx_acc_d;
  logic              pfx_bad_q, pfx_bad_d;
  logic [1:0]        lst_phase_q, lst_phase_d;
  logic              lst_neg_q, lst_neg_d;
  logic [DATA_W-1:0] lst_acc_q, lst_acc_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [DATA_W-1:0] picked_q, picked_d;
  logic [IDX_W-1:0]  latched_q, latched_d;
  logic              started_q;

  // result register
  logic              out_valid_q;
  logic [DATA_W-1:0] res_port_q, res_port_d;
  logic [DATA_W-1:0] res_pick_q, res_pick_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;

  logic              c_ws, c_dig, c_sign, c_minus;
  logic [DATA_W-1:0] pfx_sum, lst_sum;
  logic              pfx_ok, lst_ok;
  logic              commit_early, commit;
  logic [DATA_W-1:0] commit_val;
  logic [IDX_W-1:0]  eff_idx;

  assign s1_fire    = in_valid_q && (!end_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || s1_fire;

  assign c_ws    = is_ws(char_q);
  assign c_dig   = is_digit(char_q);
  assign c_minus = (char_q == CHAR_MINUS);
  assign c_sign  = (char_q == CHAR_PLUS) || c_minus;
  assign eff_idx = started_q ? latched_q : idx_in_q;

  prlp_num_acc u_pfx_acc (
    .acc_i      (pfx_acc_q),
    .negative_i (pfx_neg_q),
    .digit_i    (char_q[3:0]),
    .sum_o      (pfx_sum),
    .ok_o       (pfx_ok)
  );

  prlp_num_acc u_lst_acc (
    .acc_i      (lst_acc_q),
    .negative_i (lst_neg_q),
    .digit_i    (char_q[3:0]),
    .sum_o      (lst_sum),
    .ok_o       (lst_ok)
  );

  always_comb begin
    colon_d      = colon_q;
    p_seen_d     = p_seen_q;
    c_after_d    = c_after_q;
    c_before_d   = c_before_q;
    pfx_phase_d  = pfx_phase_q;
    pfx_neg_d    = pfx_neg_q;
    pfx_acc_d    = pfx_acc_q;
    pfx_bad_d    = pfx_bad_q;
    lst_phase_d  = lst_phase_q;
    lst_neg_d    = lst_neg_q;
    lst_acc_d    = lst_acc_q;
    count_d      = count_q;
    picked_d     = picked_q;
    latched_d    = eff_idx;
    commit_early = 1'b0;
    res_port_d   = NEG_ONE;
    res_pick_d   = NEG_ONE;
    res_stat_d   = ST_OK;

    // list after the colon
    if (colon_q) begin
      case (lst_phase_q)
        PH_DIGITS: begin
          if (c_dig) begin
            if (lst_ok) lst_acc_d = lst_sum;
            else        lst_phase_d = PH_STOP;
          end else begin
            // number ends, this byte opens the next token
            commit_early = 1'b1;
            lst_acc_d    = '0;
            lst_neg_d    = 1'b0;
            if (c_ws) begin
              lst_phase_d = PH_SKIP;
            end else if (c_sign) begin
              lst_neg_d   = c_minus;
              lst_phase_d = PH_SIGN;
            end else begin
              lst_phase_d = PH_STOP;
            end
          end
        end
        PH_SKIP: begin
          if (c_ws) begin
            lst_phase_d = PH_SKIP;
          end else if (c_sign) begin
            lst_neg_d   = c_minus;
            lst_phase_d = PH_SIGN;
          end else if (c_dig && lst_ok) begin
            lst_acc_d   = lst_sum;
            lst_phase_d = PH_DIGITS;
          end else begin
            lst_phase_d = PH_STOP;
          end
        end
        PH_SIGN: begin
          if (c_dig && lst_ok) begin
            lst_acc_d   = lst_sum;
            lst_phase_d = PH_DIGITS;
          end else begin
            lst_phase_d = PH_STOP;
          end
        end
        default: ;
      endcase
    end else if (char_q == CHAR_COLON) begin
      colon_d = 1'b1;
    end

    // at most one number completes per byte
    commit = commit_early || (end_q && lst_phase_d == PH_DIGITS);
    if (commit_early) commit_val = lst_neg_q ? (DATA_W'(0) - lst_acc_q) : lst_acc_q;
    else              commit_val = lst_neg_d ? (DATA_W'(0) - lst_acc_d) : lst_acc_d;
    if (commit && count_q < CntW'(MAX_NUMBERS)) begin
      if (!eff_idx[IDX_W-1] && CmpW'(count_q) == CmpW'(eff_idx[IDX_W-2:0])) begin
        picked_d = commit_val;
      end
      count_d = count_q + CntW'(1);
    end

    // prefix between P and C
    if (!p_seen_q) begin
      if (char_q == CHAR_P)      p_seen_d   = 1'b1;
      else if (char_q == CHAR_C) c_before_d = 1'b1;
    end else if (!c_after_q) begin
      if (char_q == CHAR_C) begin
        c_after_d = 1'b1;
      end else begin
        case (pfx_phase_q)
          PH_SKIP: begin
            if (c_ws) begin
              pfx_phase_d = PH_SKIP;
            end else if (c_sign) begin
              pfx_neg_d   = c_minus;
              pfx_phase_d = PH_SIGN;
            end else if (c_dig && pfx_ok) begin
              pfx_acc_d   = pfx_sum;
              pfx_phase_d = PH_DIGITS;
            end else begin
              pfx_bad_d   = 1'b1;
              pfx_phase_d = PH_STOP;
            end
          end
          PH_SIGN: begin
            if (c_dig && pfx_ok) begin
              pfx_acc_d   = pfx_sum;
              pfx_phase_d = PH_DIGITS;
            end else begin
              pfx_bad_d   = 1'b1;
              pfx_phase_d = PH_STOP;
            end
          end
          PH_DIGITS: begin
            if (!c_dig) begin
              pfx_phase_d = PH_STOP;
            end else if (pfx_ok) begin
              pfx_acc_d = pfx_sum;
            end else begin
              pfx_bad_d   = 1'b1;
              pfx_phase_d = PH_STOP;
            end
          end
          default: ;
        endcase
      end
    end

    // result, lowest applicable code wins
    if (!colon_d) begin
      res_stat_d = ST_NO_COLON;
    end else if (!p_seen_d || !c_after_d || c_before_d) begin
      res_stat_d = ST_BAD_ORDER;
    end else if (pfx_bad_d || pfx_phase_d == PH_SKIP || pfx_phase_d == PH_SIGN) begin
      res_stat_d = ST_BAD_PFX;
    end else begin
      res_port_d = pfx_neg_d ? (DATA_W'(0) - pfx_acc_d) : pfx_acc_d;
      if (eff_idx[IDX_W-1] || CmpW'(eff_idx[IDX_W-2:0]) >= CmpW'(count_d)) begin
        res_stat_d = ST_IDX_RANGE;
      end else begin
        res_stat_d = ST_OK;
        res_pick_d = picked_d;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      colon_q     <= 1'b0;
      p_seen_q    <= 1'b0;
      c_after_q   <= 1'b0;
      c_before_q  <= 1'b0;
      pfx_phase_q <= PH_SKIP;
      pfx_neg_q   <= 1'b0;
      pfx_acc_q   <= '0;
      pfx_bad_q   <= 1'b0;
      lst_phase_q <= PH_SKIP;
      lst_neg_q   <= 1'b0;
      lst_acc_q   <= '0;
      count_q     <= '0;
      picked_q    <= NEG_ONE;
      latched_q   <= '0;
      started_q   <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (s1_fire && end_q)    out_valid_q <= 1'b1;
      else if (out_ready_i)    out_valid_q <= 1'b0;
      if (s1_fire) begin
        if (end_q) begin
          // line done, back to the clean state
          colon_q     <= 1'b0;
          p_seen_q    <= 1'b0;
          c_after_q   <= 1'b0;
          c_before_q  <= 1'b0;
          pfx_phase_q <= PH_SKIP;
          pfx_neg_q   <= 1'b0;
          pfx_acc_q   <= '0;
          pfx_bad_q   <= 1'b0;
          lst_phase_q <= PH_SKIP;
          lst_neg_q   <= 1'b0;
          lst_acc_q   <= '0;
          count_q     <= '0;
          picked_q    <= NEG_ONE;
          latched_q   <= '0;
          started_q   <= 1'b0;
        end else begin
          colon_q     <= colon_d;
          p_seen_q    <= p_seen_d;
          c_after_q   <= c_after_d;
          c_before_q  <= c_before_d;
          pfx_phase_q <= pfx_phase_d;
          pfx_neg_q   <= pfx_neg_d;
          pfx_acc_q   <= pfx_acc_d;
          pfx_bad_q   <= pfx_bad_d;
          lst_phase_q <= lst_phase_d;
          lst_neg_q   <= lst_neg_d;
          lst_acc_q   <= lst_acc_d;
          count_q     <= count_d;
          picked_q    <= picked_d;
          latched_q   <= latched_d;
          started_q   <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q   <= char_code_i;
      idx_in_q <= wanted_index_i;
      end_q    <= line_end_i;
    end
    if (s1_fire && end_q) begin
      res_port_q <= res_port_d;
      res_pick_q <= res_pick_d;
      res_stat_q <= res_stat_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign port_number_o   = res_port_q;
  assign picked_number_o = res_pick_q;
  assign parse_status_o  = res_stat_q;

`include "port_reply_line_parser_assert.svh"

  `PRLP_ASSERT_NOW(a_err_minus_one, out_valid_q && res_stat_q != ST_OK && res_stat_q != ST_IDX_RANGE, res_port_q == NEG_ONE && res_pick_q == NEG_ONE, "structural error without -1 results")
  `PRLP_ASSERT_NOW(a_pick_on_ok_only, out_valid_q && res_stat_q != ST_OK, res_pick_q == NEG_ONE, "picked number given with nonzero status")
  `PRLP_ASSERT_NEXT(a_line_clears, s1_fire && end_q, !started_q && !colon_q && count_q == '0 && lst_phase_q == PH_SKIP, "line state not cleared after line end")
  `PRLP_ASSERT_NOW(a_count_cap, started_q, count_q <= CntW'(MAX_NUMBERS), "list count past its cap")

endmodule

// ===== sim/port_reply_line_parser_tb.sv =====
// ----------------------------------------------------------------------------
// port_reply_line_parser_tb
// Feeds reply lines a byte per word into the parser: a table of hand-made
// lines, then random lines (mostly well-formed replies, some broken text and
// raw noise). A local model of the line state predicts untyped replies; every
// reply is checked field by field, in order, while both sides stall at random.
// ----------------------------------------------------------------------------
module port_reply_line_parser_tb;
  import prlp_pkg::*;

  localparam int unsigned MAX_NUMS   = 255;
  localparam int          RAND_ITEMS = 800;
  localparam int          HOLD_LEN   = 300;
  localparam int          QUIET_MAX  = 3000;
  localparam int          NROWS      = 26;

  typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_STOP} phase_e;

  typedef struct packed {
    logic signed [31:0] port;
    logic signed [31:0] picked;
    logic [2:0]         status;
  } reply_t;

  typedef struct packed {
    logic [8*28-1:0]   text;
    logic signed [8:0] idx;
    logic [15:0]       fill;
    logic              typed;
    reply_t            want;
  } row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [7:0]               char_code_i;
  logic signed [8:0]        wanted_index_i;
  logic                     line_end_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [31:0]       port_number_o;
  logic signed [31:0]       picked_number_o;
  logic [2:0]               parse_status_o;

  // reply typed into the table for the line being driven
  logic                     drv_typed;
  reply_t                   drv_want;

  port_reply_line_parser #(.MAX_NUMBERS(MAX_NUMS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .wanted_index_i  (wanted_index_i),
    .line_end_i      (line_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .port_number_o   (port_number_o),
    .picked_number_o (picked_number_o),
    .parse_status_o  (parse_status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- line model
  logic        colon_seen, p_seen, c_after_p, c_before_p, in_line;
  phase_e      pfx_phase, lst_phase;
  logic        pfx_neg, pfx_bad, lst_neg;
  logic [31:0] pfx_mag, lst_mag, picked_val;
  int unsigned num_count;
  logic [8:0]  line_index;

  function automatic void clear_line();
    colon_seen = 1'b0; p_seen = 1'b0; c_after_p = 1'b0; c_before_p = 1'b0;
    in_line = 1'b0;
    pfx_phase = PH_SKIP; pfx_neg = 1'b0; pfx_bad = 1'b0; pfx_mag = '0;
    lst_phase = PH_SKIP; lst_neg = 1'b0; lst_mag = '0;
    num_count = 0; picked_val = '1; line_index = '0;
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  // {overflow, magnitude * 10 + digit}
  function automatic logic [32:0] mul10_add(input logic [31:0] mag, input logic neg,
                                            input logic [7:0] c);
    logic [35:0] v;
    logic [35:0] lim;
    v   = 36'(mag) * 36'd10 + 36'(c - CHAR_ZERO);
    lim = neg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
    return {v > lim, v[31:0]};
  endfunction

  function automatic void prefix_byte(input logic [7:0] c);
    logic        grow;
    logic [32:0] r;
    grow = 1'b0;
    case (pfx_phase)
      PH_SKIP: begin
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          pfx_neg = (c == CHAR_MINUS);
          pfx_phase = PH_SIGN;
        end else if (numeral(c)) begin
          grow = 1'b1;
        end else if (!blank(c)) begin
          pfx_bad = 1'b1;
          pfx_phase = PH_STOP;
        end
      end
      PH_SIGN: begin
        if (numeral(c)) grow = 1'b1;
        else begin
          pfx_bad = 1'b1;
          pfx_phase = PH_STOP;
        end
      end
      PH_DIGITS: begin
        if (numeral(c)) grow = 1'b1;
        else pfx_phase = PH_STOP;
      end
      default: ;
    endcase
    if (grow) begin
      pfx_phase = PH_DIGITS;
      r = mul10_add(pfx_mag, pfx_neg, c);
      if (r[32]) begin
        pfx_bad = 1'b1;
        pfx_phase = PH_STOP;
      end else begin
        pfx_mag = r[31:0];
      end
    end
  endfunction

  function automatic void list_take();
    logic [31:0] v;
    v = lst_neg ? (32'd0 - lst_mag) : lst_mag;
    if (num_count < MAX_NUMS) begin
      if (!line_index[8] && num_count == line_index) picked_val = v;
      num_count++;
    end
    lst_mag = '0;
    lst_neg = 1'b0;
    lst_phase = PH_SKIP;
  endfunction

  function automatic void list_byte(input logic [7:0] c);
    logic        grow;
    logic [32:0] r;
    grow = 1'b0;
    // a non-digit after a number closes it and then starts the next token
    if (lst_phase == PH_DIGITS && !numeral(c)) list_take();
    case (lst_phase)
      PH_SKIP: begin
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          lst_neg = (c == CHAR_MINUS);
          lst_phase = PH_SIGN;
        end else if (numeral(c)) begin
          grow = 1'b1;
        end else if (!blank(c)) begin
          lst_phase = PH_STOP;
        end
      end
      PH_SIGN: begin
        if (numeral(c)) grow = 1'b1;
        else lst_phase = PH_STOP;
      end
      PH_DIGITS: grow = 1'b1;
      default: ;
    endcase
    if (grow) begin
      lst_phase = PH_DIGITS;
      r = mul10_add(lst_mag, lst_neg, c);
      if (r[32]) lst_phase = PH_STOP;
      else lst_mag = r[31:0];
    end
  endfunction

  function automatic bit parse_byte(input logic [7:0] c, input logic [8:0] idx,
                                    input logic last, output reply_t r);
    if (!in_line) begin
      line_index = idx;
      in_line = 1'b1;
    end
    if (colon_seen) list_byte(c);
    else if (c == CHAR_COLON) colon_seen = 1'b1;
    if (!p_seen) begin
      if (c == CHAR_P) p_seen = 1'b1;
      else if (c == CHAR_C) c_before_p = 1'b1;
    end else if (!c_after_p) begin
      if (c == CHAR_C) c_after_p = 1'b1;
      else prefix_byte(c);
    end
    r = '0;
    if (!last) return 1'b0;
    if (colon_seen && lst_phase == PH_DIGITS) list_take();
    r.port = -32'sd1;
    r.picked = -32'sd1;
    if (!colon_seen) r.status = ST_NO_COLON;
    else if (!p_seen || !c_after_p || c_before_p) r.status = ST_BAD_ORDER;
    else if (pfx_bad || pfx_phase != PH_DIGITS && pfx_phase != PH_STOP) r.status = ST_BAD_PFX;
    else begin
      r.port = pfx_neg ? (32'd0 - pfx_mag) : pfx_mag;
      if (line_index[8] || line_index >= num_count) r.status = ST_IDX_RANGE;
      else begin
        r.status = ST_OK;
        r.picked = picked_val;
      end
    end
    clear_line();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- directed lines
  row_t plan [NROWS] = '{
    '{"P1C:5",                     9'h000, 16'd0,   1'b1,
      '{32'sd1, 32'sd5, ST_OK}},
    '{"hello",                     9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_NO_COLON}},
    '{"C P1C: 3",                  9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_BAD_ORDER}},
    '{":1 2",                      9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_BAD_ORDER}},
    '{"P1: 2",                     9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_BAD_ORDER}},
    '{"P C:1",                     9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_BAD_PFX}},
    '{"Px1C:1",                    9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_BAD_PFX}},
    '{"P+C:1",                     9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_BAD_PFX}},
    '{"P2147483647C:0",            9'h000, 16'd0,   1'b1,
      '{32'sh7FFF_FFFF, 32'sd0, ST_OK}},
    '{"P-2147483648C:-2147483648", 9'h000, 16'd0,   1'b1,
      '{32'sh8000_0000, 32'sh8000_0000, ST_OK}},
    '{"P2147483648C:1",            9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_BAD_PFX}},
    '{"P-2147483649C:1",           9'h000, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_BAD_PFX}},
    '{"P 7 xyzC: 1 2 3",           9'h002, 16'd0,   1'b1,
      '{32'sd7, 32'sd3, ST_OK}},
    '{"P1C:12-3",                  9'h001, 16'd0,   1'b1,
      '{32'sd1, -32'sd3, ST_OK}},
    '{"P1C:1 2",                   9'h005, 16'd0,   1'b1,
      '{32'sd1, -32'sd1, ST_IDX_RANGE}},
    '{"P1C:1 2",                   9'h1FF, 16'd0,   1'b1,
      '{32'sd1, -32'sd1, ST_IDX_RANGE}},
    '{"P1C:1 + 2",                 9'h001, 16'd0,   1'b1,
      '{32'sd1, -32'sd1, ST_IDX_RANGE}},
    '{"P1C:1 2147483648 5",        9'h001, 16'd0,   1'b1,
      '{32'sd1, -32'sd1, ST_IDX_RANGE}},
    '{"Z",                         9'h100, 16'd0,   1'b1,
      '{-32'sd1, -32'sd1, ST_NO_COLON}},
    '{"P1C:-2147483648 x 3",       9'h000, 16'd0,   1'b0, '0},
    '{"P+5C:\t\n\015\013 4",       9'h000, 16'd0,   1'b0, '0},
    '{":P1C 9",                    9'h000, 16'd0,   1'b0, '0},
    '{"P3CC:1",                    9'h000, 16'd0,   1'b0, '0},
    '{"P1C:\377 1",                9'h000, 16'd0,   1'b0, '0},
    '{"P1C:1 2 3 4 5",             9'h0FF, 16'd0,   1'b0, '0},
    '{"P1C:",                      9'h0FE, 16'd256, 1'b0, '0}
  };

  // ---------------------------------------------------------------- bookkeeping
  reply_t      awaited_replies[$];
  logic [7:0]  line_bytes[$];
  int          mismatches;
  int          reply_count;
  int          status_tally[8];
  int          bytes_total;
  int          rand_bytes;
  int          lines_total;
  int          quiet_cycles;
  bit          calm;
  bit          hold_req;
  int          hold_left;

  // ---------------------------------------------------------------- receiver
  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 36);
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : watch
    reply_t calc;
    reply_t got;
    reply_t want;
    bit     has;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        has = parse_byte(char_code_i, wanted_index_i, line_end_i, calc);
        if (has)
          awaited_replies.insert(awaited_replies.size(), drv_typed ? drv_want : calc);
      end
      if (out_valid_o && out_ready_i) begin
        got.port = port_number_o;
        got.picked = picked_number_o;
        got.status = parse_status_o;
        status_tally[got.status]++;
        reply_count++;
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply %0d arrived with none awaited: port %0d picked %0d status %0d",
                     reply_count, got.port, got.picked, got.status);
        end else begin
          want = awaited_replies.pop_front();
          if (got.port !== want.port || got.picked !== want.picked ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply %0d: expected port %0d picked %0d status %0d, got %0d %0d %0d",
                       reply_count, want.port, want.picked, want.status,
                       got.port, got.picked, got.status);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("no word moved for %0d cycles, giving up", QUIET_MAX);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_byte(input logic [7:0] c, input logic [8:0] idx, input logic last,
                           input logic typed, input reply_t want);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= c;
    wanted_index_i <= idx;
    line_end_i     <= last;
    drv_typed      <= typed;
    drv_want       <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // wanted_index only counts on the first byte, so the rest carry junk
  task automatic send_line(input logic [8:0] idx, input logic typed, input reply_t want);
    for (int i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], (i == 0) ? idx : 9'($urandom),
                i == line_bytes.size() - 1, typed, want);
    bytes_total += line_bytes.size();
    lines_total++;
  endtask

  task automatic drain_replies();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- line builders
  task automatic add_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_blanks(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 6);
      add_byte(k < 5 ? CHAR_TAB + 8'(k) : CHAR_SPACE);
    end
  endtask

  function automatic string number_text();
    case ($urandom_range(0, 9))
      5: return $sformatf("%0d", $urandom);
      6: begin
        case ($urandom_range(0, 2))
          0: return "2147483647";
          1: return "2147483648";
          default: return "2147483649";
        endcase
      end
      7: return $sformatf("00%0d", $urandom_range(0, 99));
      8: return "99999999999";
      9: return $sformatf("%0d", $urandom_range(0, 99999));
      default: return $sformatf("%0d", $urandom_range(0, 99));
    endcase
  endfunction

  task automatic build_reply_line(output logic [8:0] idx);
    int n;
    int sep;
    int pick;
    bit big;
    line_bytes.delete();
    case ($urandom_range(0, 7))
      0: add_text("M0 ");
      1: add_text("C ");
      default: ;
    endcase
    add_byte(CHAR_P);
    add_blanks($urandom_range(0, 2));
    if ($urandom_range(0, 2) == 0)
      add_byte($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
    add_text(number_text());
    if ($urandom_range(0, 3) == 0) add_text(" ok");
    add_byte(CHAR_C);
    if ($urandom_range(0, 3) == 0) add_text(" s");
    add_byte(CHAR_COLON);
    big = ($urandom_range(0, 99) == 0);
    n = big ? $urandom_range(250, 262) : $urandom_range(0, 6);
    for (int k = 0; k < n; k++) begin
      if (big) begin
        add_text($sformatf(" %0d", $urandom_range(0, 9)));
      end else begin
        sep = $urandom_range(0, 2);
        add_blanks(sep);
        // with no gap a sign must split the numbers
        if ((sep == 0 && k > 0) || $urandom_range(0, 3) == 0)
          add_byte($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
        add_text(number_text());
      end
    end
    case ($urandom_range(0, 7))
      0: add_blanks($urandom_range(1, 2));
      1: add_text(" x");
      2: add_text(" -");
      3: add_text(" 99999999999 7");
      default: ;
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) idx = 9'(-$urandom_range(1, 256));
    else if (pick == 1) idx = 9'($urandom);
    else if (big) idx = 9'($urandom_range(240, 255));
    else idx = 9'($urandom_range(0, n + 1));
  endtask

  task automatic build_garbled_line(output logic [8:0] idx);
    string alphabet;
    int    n;
    alphabet = "PC:+-0129 \tx";
    line_bytes.delete();
    n = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) add_byte(8'($urandom));
      else add_byte(alphabet[$urandom_range(0, alphabet.len() - 1)]);
    end
    idx = 9'($urandom);
  endtask

  task automatic build_noise_line(output logic [8:0] idx);
    int n;
    line_bytes.delete();
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
    idx = 9'($urandom);
  endtask

  task automatic run_row(input row_t r);
    logic [7:0] b;
    bit         started;
    started = 1'b0;
    line_bytes.delete();
    // text sits right-aligned in the field, zero bytes ahead of it
    for (int k = 27; k >= 0; k--) begin
      b = r.text[8*k +: 8];
      if (started || b != 8'h00) begin
        started = 1'b1;
        add_byte(b);
      end
    end
    for (int i = 0; i < r.fill; i++) add_text($sformatf("%0d ", i % 10));
    send_line(r.idx, r.typed, r.want);
  endtask

  // ---------------------------------------------------------------- main sequence
  initial begin : main
    logic [8:0] idx;
    int         kind;
    int         rand_lines;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    char_code_i = '0;
    wanted_index_i = '0;
    line_end_i = 1'b0;
    drv_typed = 1'b0;
    drv_want = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    mismatches = 0;
    reply_count = 0;
    bytes_total = 0;
    rand_bytes = 0;
    lines_total = 0;
    quiet_cycles = 0;
    rand_lines = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    clear_line();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NROWS; i++) run_row(plan[i]);
    drain_replies();

    while (rand_bytes < RAND_ITEMS) begin
      // long receiver hold-off so the parser backs up onto its input
      if (rand_lines == 3) hold_req = 1'b1;
      if (rand_lines == 10) calm = 1'b1;
      if (rand_lines == 22) calm = 1'b0;
      if (rand_lines == 28) drain_replies();
      kind = $urandom_range(0, 99);
      if (kind < 72) build_reply_line(idx);
      else if (kind < 90) build_garbled_line(idx);
      else build_noise_line(idx);
      rand_bytes += line_bytes.size();
      send_line(idx, 1'b0, '0);
      rand_lines++;
    end

    drain_replies();
    repeat (8) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      $display("%0d replies never arrived", awaited_replies.size());
      mismatches += awaited_replies.size();
    end

    $display("sent %0d lines, %0d bytes (%0d random), checked %0d replies",
             lines_total, bytes_total, rand_bytes, reply_count);
    $display("status mix: ok %0d, no colon %0d, order %0d, prefix %0d, index %0d",
             status_tally[ST_OK], status_tally[ST_NO_COLON], status_tally[ST_BAD_ORDER],
             status_tally[ST_BAD_PFX], status_tally[ST_IDX_RANGE]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
